/* src/blsz_pkg.sv */
// blob list size statistics: shared types, codes and constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package blsz_pkg;

  localparam logic [31:0] ALIGN_RESET = 32'd64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FN_OPEN = 2'd0,
    FN_BLOB = 2'd1,
    FN_END  = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RK_SIZE  = 2'd0,
    RK_STATS = 2'd1,
    RK_ERROR = 2'd2
  } kind_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ALIGN    = 3'd1;
  localparam logic [2:0] ST_HEADER   = 3'd2;
  localparam logic [2:0] ST_COMPOSED = 3'd3;
  localparam logic [2:0] ST_BLOB     = 3'd4;
  localparam logic [2:0] ST_COUNTSUM = 3'd5;

  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam logic [63:0] I64MIN = {1'b1, 63'd0};
  localparam logic [63:0] I64MAX = {1'b0, {63{1'b1}}};
  // largest count whose header (count+2)*8 fits in 64 bits
  localparam logic [63:0] MAX_HDR_COUNT = 64'h1FFF_FFFF_FFFF_FFFD;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [63:0] composed_size;
    logic [62:0] list_count;
    logic [62:0] total_bytes;
    logic [62:0] fewest_blobs;
    logic [62:0] most_blobs;
    logic [62:0] mean_blobs;
    logic [62:0] smallest_blob;
    logic signed [63:0] largest_blob;
    logic [62:0] mean_blob;
  } out_item_t;

  // item after classification by the front part
  typedef struct packed {
    func_t       func;
    logic [63:0] value;
    logic        bad_align;
    logic        hdr_ovf;
    logic [63:0] header;
  } cls_item_t;

endpackage
`default_nettype wire

/* src/blsz_front.sv */
// front part: registers items, checks alignment and overflow, computes aligned header
// depends on blsz_pkg
`timescale 1ns / 1ps
`default_nettype none
module blsz_front
  import blsz_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [31:0] align,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           q_valid,
  input  wire logic      q_stall,
  output cls_item_t      q_data
);

  logic      v_r, v_nxt;
  in_item_t  d_r;
  logic [63:0] pad;
  logic [63:0] raw;
  logic [64:0] hsum;

  assign in_stall = v_r && q_stall;
  assign v_nxt    = in_stall ? v_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (!in_stall && in_valid) begin
      d_r <= in_data;
    end
  end

  always_comb begin
    pad  = {32'd0, align - 32'd1};
    raw  = (d_r.item_value + 64'd2) << 3;
    hsum = {1'b0, raw} + {1'b0, pad};
    q_valid        = v_r;
    q_data.func    = func_t'(d_r.func);
    q_data.value   = d_r.item_value;
    q_data.bad_align = (align == 32'd0) || ((align & (align - 32'd1)) != 32'd0);
    q_data.hdr_ovf = (d_r.item_value > MAX_HDR_COUNT) || hsum[64];
    q_data.header  = hsum[63:0] & ~pad;
  end

endmodule
`default_nettype wire

/* src/blsz_queue.sv */
// short fifo between front and back parts
// depends on blsz_pkg
`timescale 1ns / 1ps
`default_nettype none
module blsz_queue
  import blsz_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_stall,
  input  wire cls_item_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_stall,
  output cls_item_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cls_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic wr, rd;

  assign wr_stall = (cnt_r == (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (wr) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    if (rd) rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    cnt_nxt = cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count overrun");
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    wr_stall |-> !wr) else $error("write into full queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> cnt_r == $past(cnt_r) + (AW+1)'(1)) else $error("count step");

endmodule
`default_nettype wire

/* src/blsz_back.sv */
// back part: updates request statistics, divides at end of request, drives results
// depends on blsz_pkg
`timescale 1ns / 1ps
`default_nettype none
module blsz_back
  import blsz_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  output logic           q_stall,
  input  wire cls_item_t q_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_DIV1 = 4'b0010,
    S_DIV2 = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t st_r, st_nxt;
  logic [62:0] lists_r, lists_nxt;
  logic [62:0] csum_r, csum_nxt;
  logic [63:0] blobs_r, blobs_nxt;
  logic [62:0] bytes_r, bytes_nxt;
  logic [63:0] minl_r, minl_nxt, maxl_r, maxl_nxt;
  logic [63:0] minb_r, minb_nxt, maxb_r, maxb_nxt;
  logic [63:0] run_r, run_nxt;
  logic [62:0] left_r, left_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;

  // shared restoring divider, one bit a cycle
  logic [63:0] dq_r, dq_nxt, dd_r, dd_nxt;
  logic [64:0] drem_r, drem_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic [64:0] trial;

  logic [63:0] v;
  logic [64:0] s65;
  logic [63:0] bsum;
  logic        take;

  assign v = q_data.value;
  assign q_stall = (st_r != S_RUN) || ov_r;
  assign take = q_valid && !q_stall;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    st_nxt = st_r;
    lists_nxt = lists_r; csum_nxt = csum_r; blobs_nxt = blobs_r; bytes_nxt = bytes_r;
    minl_nxt = minl_r; maxl_nxt = maxl_r; minb_nxt = minb_r; maxb_nxt = maxb_r;
    run_nxt = run_r; left_nxt = left_r; err_nxt = err_r;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    dq_nxt = dq_r; dd_nxt = dd_r; drem_nxt = drem_r; dcnt_nxt = dcnt_r;
    trial = {drem_r[63:0], dq_r[63]} - {1'b0, dd_r};
    s65 = '0;
    bsum = '0;
    unique case (st_r)
      S_RUN: begin
        if (take) begin
          od_nxt = '0;
          if (q_data.func == FN_END) begin
            if (err_r != ST_OK) begin
              od_nxt.result_kind = RK_ERROR;
              od_nxt.status = err_r;
              ov_nxt = 1'b1;
              lists_nxt = '0; csum_nxt = '0; blobs_nxt = '0; bytes_nxt = '0;
              minl_nxt = I64MAX; maxl_nxt = I64MIN; minb_nxt = I64MAX;
              maxb_nxt = I64MIN; run_nxt = '0; left_nxt = '0; err_nxt = ST_OK;
            end else begin
              od_nxt.result_kind = RK_STATS;
              od_nxt.list_count = lists_r;
              od_nxt.total_bytes = bytes_r;
              od_nxt.fewest_blobs = minl_r[62:0];
              od_nxt.most_blobs = maxl_r[62:0];
              od_nxt.smallest_blob = minb_r[62:0];
              od_nxt.largest_blob = maxb_r;
              dq_nxt = {1'b0, csum_r};
              dd_nxt = {1'b0, lists_r};
              drem_nxt = '0;
              dcnt_nxt = 7'd64;
              st_nxt = S_DIV1;
            end
          end else if (err_r == ST_OK && q_data.func == FN_OPEN) begin
            s65 = {2'b0, csum_r} + {1'b0, v};
            if (q_data.bad_align) begin
              err_nxt = ST_ALIGN;
            end else if (q_data.hdr_ovf) begin
              err_nxt = ST_HEADER;
            end else if (s65 > {2'b0, MAX63}) begin
              err_nxt = ST_COUNTSUM;
            end else begin
              csum_nxt = s65[62:0];
              if (lists_r != MAX63) lists_nxt = lists_r + 63'd1;
              if (v < minl_r) minl_nxt = v;
              if ($signed(v) > $signed(maxl_r)) maxl_nxt = v;
              run_nxt = q_data.header;
              left_nxt = v[62:0];
              if (v == '0) begin
                od_nxt.result_kind = RK_SIZE;
                od_nxt.composed_size = q_data.header;
                ov_nxt = 1'b1;
              end
            end
            if (err_nxt != ST_OK) begin
              od_nxt.result_kind = RK_ERROR;
              od_nxt.status = err_nxt;
              ov_nxt = 1'b1;
            end
          end else if (err_r == ST_OK && q_data.func == FN_BLOB && left_r != '0) begin
            s65 = {1'b0, run_r} + {1'b0, v};
            if (s65[64]) begin
              err_nxt = ST_COMPOSED;
            end else begin
              run_nxt = s65[63:0];
              if (v[63]) begin
                err_nxt = ST_BLOB;
              end else begin
                bsum = {1'b0, bytes_r} + v;
                bytes_nxt = bsum[63] ? MAX63 : bsum[62:0];
                if (v < minb_r) minb_nxt = v;
                if ($signed(v) > $signed(maxb_r)) maxb_nxt = v;
                blobs_nxt = blobs_r + 64'd1;
                left_nxt = left_r - 63'd1;
                if (left_r == 63'd1) begin
                  od_nxt.result_kind = RK_SIZE;
                  od_nxt.composed_size = s65[63:0];
                  ov_nxt = 1'b1;
                end
              end
            end
            if (err_nxt != ST_OK) begin
              od_nxt.result_kind = RK_ERROR;
              od_nxt.status = err_nxt;
              ov_nxt = 1'b1;
            end
          end
        end
      end
      S_DIV1, S_DIV2: begin
        if (dcnt_r != '0) begin
          if (!trial[64]) begin
            drem_nxt = trial;
            dq_nxt = {dq_r[62:0], 1'b1};
          end else begin
            drem_nxt = {drem_r[63:0], dq_r[63]};
            dq_nxt = {dq_r[62:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 7'd1;
        end else if (st_r == S_DIV1) begin
          od_nxt.mean_blobs = (dd_r == '0) ? '0 : dq_r[62:0];
          dq_nxt = {1'b0, bytes_r};
          dd_nxt = blobs_r;
          drem_nxt = '0;
          dcnt_nxt = 7'd64;
          st_nxt = S_DIV2;
        end else begin
          od_nxt.mean_blob = (dd_r == '0) ? '0 : dq_r[62:0];
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = S_RUN;
        lists_nxt = '0; csum_nxt = '0; blobs_nxt = '0; bytes_nxt = '0;
        minl_nxt = I64MAX; maxl_nxt = I64MIN; minb_nxt = I64MAX;
        maxb_nxt = I64MIN; run_nxt = '0; left_nxt = '0; err_nxt = ST_OK;
      end
      default: st_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RUN;
      ov_r <= 1'b0;
      lists_r <= '0; csum_r <= '0; blobs_r <= '0; bytes_r <= '0;
      minl_r <= I64MAX; maxl_r <= I64MIN; minb_r <= I64MAX; maxb_r <= I64MIN;
      run_r <= '0; left_r <= '0; err_r <= ST_OK;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      lists_r <= lists_nxt; csum_r <= csum_nxt; blobs_r <= blobs_nxt;
      bytes_r <= bytes_nxt; minl_r <= minl_nxt; maxl_r <= maxl_nxt;
      minb_r <= minb_nxt; maxb_r <= maxb_nxt; run_r <= run_nxt;
      left_r <= left_nxt; err_r <= err_nxt;
    end
    od_r <= od_nxt;
    dq_r <= dq_nxt; dd_r <= dd_nxt; drem_r <= drem_nxt; dcnt_r <= dcnt_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r && $stable(od_r)) else $error("result lost");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_RUN) |-> !take) else $error("item taken during division");
  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r == S_DONE) |=> err_r == ST_OK) else $error("error kept into stats");

endmodule
`default_nettype wire

/* src/blob_list_size_statistics.sv */
// blob list size statistics, top level: config register, front, queue, back
// depends on blsz_pkg, blsz_front, blsz_queue, blsz_back
// list and error items: front register, queue, back output register, then out_valid
// throughput: one item per cycle; a waiting result or a division holds the back part
// end of request: stats come after two 64-step serial divisions
// reset: synchronous active low, clears statistics, alignment returns to 64
`timescale 1ns / 1ps
`default_nettype none
module blob_list_size_statistics
  import blsz_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] align_r;
  logic fq_valid, fq_stall, qb_valid, qb_stall;
  cls_item_t fq_data, qb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= ALIGN_RESET;
    end else if (cfg_valid) begin
      align_r <= cfg_data;
    end
  end

  blsz_front u_front (
    .clk, .rst_n, .align(align_r),
    .in_valid, .in_stall, .in_data,
    .q_valid(fq_valid), .q_stall(fq_stall), .q_data(fq_data)
  );

  blsz_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_data)
  );

  blsz_back u_back (
    .clk, .rst_n,
    .q_valid(qb_valid), .q_stall(qb_stall), .q_data(qb_data),
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire
